/* design/fse_pkg.sv */
// Shared types, constants and codes for the four-segment linear envelope.
`default_nettype none

package fse_pkg;

  // Field and datapath widths
  localparam int LEVEL_BITS   = 16;
  localparam int TIME_BITS    = 16;
  localparam int ELAPSED_BITS = TIME_BITS + 2;
  localparam int NUM_BITS     = LEVEL_BITS + TIME_BITS;
  localparam int SEG_BITS     = 3;
  localparam int CFG_IDX_BITS = 3;
  localparam int DIV_CNT_BITS = $clog2(LEVEL_BITS);

  localparam logic [LEVEL_BITS-1:0]   LEVEL_MAX   = {LEVEL_BITS{1'b1}};
  localparam logic [ELAPSED_BITS-1:0] ELAPSED_MAX = {ELAPSED_BITS{1'b1}};

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_ATTACK_LEVEL  = 3'd0,
    REG_ATTACK_TICKS  = 3'd1,
    REG_DECAY_LEVEL   = 3'd2,
    REG_DECAY_TICKS   = 3'd3,
    REG_SUSTAIN_LEVEL = 3'd4,
    REG_SUSTAIN_TICKS = 3'd5,
    REG_RELEASE_TICKS = 3'd6,
    REG_INVERT        = 3'd7
  } cfg_idx_t;

  // Segment codes as shown on the output
  typedef enum logic [SEG_BITS-1:0] {
    SEG_IDLE    = 3'd0,
    SEG_ATTACK  = 3'd1,
    SEG_DECAY   = 3'd2,
    SEG_SUSTAIN = 3'd3,
    SEG_RELEASE = 3'd4
  } seg_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEL,
    ST_MUL,
    ST_DIV,
    ST_OUT
  } state_t;

  // Divider status toward the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

/* design/fse_div.sv */
// Bit-serial restoring divider: one quotient bit per cycle, quotient known to fit LEVEL_BITS.
`default_nettype none

module fse_div (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               start,
  input  wire logic [fse_pkg::NUM_BITS-1:0]       num,
  input  wire logic [fse_pkg::TIME_BITS-1:0]      den,
  output fse_pkg::div_stat_t                      stat,
  output logic      [fse_pkg::LEVEL_BITS-1:0]     quot
);

  localparam int TB = fse_pkg::TIME_BITS;
  localparam int LB = fse_pkg::LEVEL_BITS;
  localparam logic [fse_pkg::DIV_CNT_BITS-1:0] CNT_LAST =
    fse_pkg::DIV_CNT_BITS'(LB - 1);

  logic [TB-1:0]                     rem_r, rem_nxt;
  logic [LB-1:0]                     quo_r, quo_nxt;
  logic [TB-1:0]                     den_r;
  logic [fse_pkg::DIV_CNT_BITS-1:0]  cnt_r;
  logic                              busy_r, done_r;
  logic [TB:0]                       r_ext;
  logic [TB:0]                       r_sub;
  logic                              ge;

  // One trial subtraction per cycle
  always_comb begin
    r_ext   = {rem_r, quo_r[LB-1]};
    r_sub   = r_ext - {1'b0, den_r};
    ge      = (r_ext >= {1'b0, den_r});
    rem_nxt = ge ? r_sub[TB-1:0] : r_ext[TB-1:0];
    quo_nxt = {quo_r[LB-2:0], ge};
  end

  // Control: busy while stepping, done is a one-cycle pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == CNT_LAST) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // Datapath: high part of the numerator is already below the divisor
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[fse_pkg::NUM_BITS-1 -: TB];
      quo_r <= num[LB-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = quo_r;

endmodule

`default_nettype wire

/* design/four_segment_linear_envelope.sv */
// Top level: config registers, envelope sequencer, shared multiply and serial divide.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid in_ready in_trigger            | in
//  out     | out_valid out_ready out_level           | out
//          | out_running out_segment                 |
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data  | in
//
// A word inside a segment goes through the select, multiply, divide and output
// states before its result shows; with no segment selected it goes from select
// straight to output. The bit-serial divider sets the longer path.
// A new input word is taken once the previous result sits in the output register.
// The result register holds while out_ready is low; the sequencer waits on it.
// rst_n is synchronous, active low; config returns to its reset defaults.
`default_nettype none

module four_segment_linear_envelope (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  in_trigger,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic      [fse_pkg::LEVEL_BITS-1:0]        out_level,
  output logic                                       out_running,
  output logic      [fse_pkg::SEG_BITS-1:0]          out_segment,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [fse_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [fse_pkg::LEVEL_BITS-1:0]        cfg_data
);

  localparam int LB = fse_pkg::LEVEL_BITS;
  localparam int TB = fse_pkg::TIME_BITS;
  localparam int EB = fse_pkg::ELAPSED_BITS;

  // Configuration registers
  logic [LB-1:0] attack_level_r, decay_level_r, sustain_level_r;
  logic [TB-1:0] attack_ticks_r, decay_ticks_r, sustain_ticks_r, release_ticks_r;
  logic          invert_r;

  // Sequencer and envelope state
  fse_pkg::state_t state_r, state_nxt;
  logic            active_r, active_nxt;
  logic [EB-1:0]   elapsed_r, elapsed_nxt;

  // Per-word working registers
  logic [LB-1:0]   lo_r, lo_nxt;
  logic [LB-1:0]   diff_r, diff_nxt;
  logic [TB-1:0]   mpos_r, mpos_nxt;
  logic [TB-1:0]   dur_r, dur_nxt;
  fse_pkg::seg_t   seg_r, seg_nxt;
  logic [LB-1:0]   lvl_r, lvl_nxt;

  // Output register
  logic            out_valid_r, out_valid_nxt;
  logic [LB-1:0]   out_level_r, out_level_nxt;
  logic            out_running_r, out_running_nxt;
  fse_pkg::seg_t   out_seg_r, out_seg_nxt;

  // Divider hookup
  logic                          div_start;
  logic [fse_pkg::NUM_BITS-1:0]  div_num;
  fse_pkg::div_stat_t            div_stat;
  logic [LB-1:0]                 div_quot;

  // Segment selection signals
  logic [EB-1:0]   e1, e2, e3, e4;
  logic            sel_hit;
  fse_pkg::seg_t   sel_seg;
  logic [LB-1:0]   sel_a, sel_b;
  logic [EB-1:0]   sel_pos;
  logic [TB-1:0]   sel_dur;
  logic [TB-1:0]   pos16;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == fse_pkg::ST_IDLE);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_level_r  <= 16'd65535;
      attack_ticks_r  <= 16'd10;
      decay_level_r   <= 16'd49152;
      decay_ticks_r   <= 16'd100;
      sustain_level_r <= 16'd32768;
      sustain_ticks_r <= 16'd500;
      release_ticks_r <= 16'd200;
      invert_r        <= 1'b0;
    end else if (cfg_valid) begin
      unique case (fse_pkg::cfg_idx_t'(cfg_index))
        fse_pkg::REG_ATTACK_LEVEL:  attack_level_r  <= cfg_data;
        fse_pkg::REG_ATTACK_TICKS:  attack_ticks_r  <= cfg_data;
        fse_pkg::REG_DECAY_LEVEL:   decay_level_r   <= cfg_data;
        fse_pkg::REG_DECAY_TICKS:   decay_ticks_r   <= cfg_data;
        fse_pkg::REG_SUSTAIN_LEVEL: sustain_level_r <= cfg_data;
        fse_pkg::REG_SUSTAIN_TICKS: sustain_ticks_r <= cfg_data;
        fse_pkg::REG_RELEASE_TICKS: release_ticks_r <= cfg_data;
        fse_pkg::REG_INVERT:        invert_r        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Segment end points and selection against the elapsed count
  always_comb begin
    e1 = {2'b00, attack_ticks_r};
    e2 = e1 + {2'b00, decay_ticks_r};
    e3 = e2 + {2'b00, sustain_ticks_r};
    e4 = e3 + {2'b00, release_ticks_r};
    sel_hit = 1'b1;
    sel_seg = fse_pkg::SEG_IDLE;
    sel_a   = '0;
    sel_b   = '0;
    sel_pos = '0;
    sel_dur = '0;
    priority if (attack_ticks_r != '0 && elapsed_r <= e1) begin
      sel_seg = fse_pkg::SEG_ATTACK;
      sel_b   = attack_level_r;
      sel_pos = elapsed_r;
      sel_dur = attack_ticks_r;
    end else if (decay_ticks_r != '0 && elapsed_r >= e1 && elapsed_r <= e2) begin
      sel_seg = fse_pkg::SEG_DECAY;
      sel_a   = attack_level_r;
      sel_b   = decay_level_r;
      sel_pos = elapsed_r - e1;
      sel_dur = decay_ticks_r;
    end else if (sustain_ticks_r != '0 && elapsed_r >= e2 && elapsed_r <= e3) begin
      sel_seg = fse_pkg::SEG_SUSTAIN;
      sel_a   = decay_level_r;
      sel_b   = sustain_level_r;
      sel_pos = elapsed_r - e2;
      sel_dur = sustain_ticks_r;
    end else if (release_ticks_r != '0 && elapsed_r >= e3 && elapsed_r <= e4) begin
      sel_seg = fse_pkg::SEG_RELEASE;
      sel_a   = sustain_level_r;
      sel_pos = elapsed_r - e3;
      sel_dur = release_ticks_r;
    end else begin
      sel_hit = 1'b0;
    end
    pos16 = sel_pos[TB-1:0];
  end

  // Shared multiplier feeds the divider directly
  assign div_num = diff_r * mpos_r;

  fse_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (dur_r),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  // Sequencer
  always_comb begin
    state_nxt       = state_r;
    active_nxt      = active_r;
    elapsed_nxt     = elapsed_r;
    lo_nxt          = lo_r;
    diff_nxt        = diff_r;
    mpos_nxt        = mpos_r;
    dur_nxt         = dur_r;
    seg_nxt         = seg_r;
    lvl_nxt         = lvl_r;
    div_start       = 1'b0;
    out_valid_nxt   = out_valid_r && !out_ready;
    out_level_nxt   = out_level_r;
    out_running_nxt = out_running_r;
    out_seg_nxt     = out_seg_r;

    unique case (state_r)
      fse_pkg::ST_IDLE: begin
        if (in_valid) begin
          // start only from idle; a trigger while running is dropped
          if (in_trigger && !active_r) begin
            active_nxt  = 1'b1;
            elapsed_nxt = '0;
          end
          state_nxt = fse_pkg::ST_SEL;
        end
      end

      fse_pkg::ST_SEL: begin
        if (!active_r) begin
          seg_nxt   = fse_pkg::SEG_IDLE;
          lvl_nxt   = '0;
          state_nxt = fse_pkg::ST_OUT;
        end else if (!sel_hit) begin
          // past the last segment: go idle on this word
          active_nxt = 1'b0;
          seg_nxt    = fse_pkg::SEG_IDLE;
          lvl_nxt    = '0;
          state_nxt  = fse_pkg::ST_OUT;
        end else begin
          // rising ramp: lo + d*pos/dur, falling: lo + d*(dur-pos)/dur
          seg_nxt = sel_seg;
          dur_nxt = sel_dur;
          if (sel_b >= sel_a) begin
            lo_nxt   = sel_a;
            diff_nxt = sel_b - sel_a;
            mpos_nxt = pos16;
          end else begin
            lo_nxt   = sel_b;
            diff_nxt = sel_a - sel_b;
            mpos_nxt = sel_dur - pos16;
          end
          state_nxt = fse_pkg::ST_MUL;
        end
      end

      fse_pkg::ST_MUL: begin
        div_start = 1'b1;
        state_nxt = fse_pkg::ST_DIV;
      end

      fse_pkg::ST_DIV: begin
        if (div_stat.done) begin
          lvl_nxt = lo_r + div_quot;
          if (elapsed_r != fse_pkg::ELAPSED_MAX) begin
            elapsed_nxt = elapsed_r + 1'b1;
          end
          state_nxt = fse_pkg::ST_OUT;
        end
      end

      fse_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt   = 1'b1;
          out_level_nxt   = invert_r ? (fse_pkg::LEVEL_MAX - lvl_r) : lvl_r;
          out_running_nxt = active_r;
          out_seg_nxt     = seg_r;
          state_nxt       = fse_pkg::ST_IDLE;
        end
      end

      default: state_nxt = fse_pkg::ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fse_pkg::ST_IDLE;
      active_r    <= 1'b0;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    lo_r          <= lo_nxt;
    diff_r        <= diff_nxt;
    mpos_r        <= mpos_nxt;
    dur_r         <= dur_nxt;
    seg_r         <= seg_nxt;
    lvl_r         <= lvl_nxt;
    out_level_r   <= out_level_nxt;
    out_running_r <= out_running_nxt;
    out_seg_r     <= out_seg_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_level   = out_level_r;
  assign out_running = out_running_r;
  assign out_segment = out_seg_r;

endmodule

`default_nettype wire

/* design/fse_checker.sv */
// Port-level checks for the envelope block, bound onto the top level.
`default_nettype none

module fse_port_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_valid,
  input wire logic                               in_ready,
  input wire logic                               out_valid,
  input wire logic                               out_ready,
  input wire logic [fse_pkg::LEVEL_BITS-1:0]     out_level,
  input wire logic                               out_running,
  input wire logic [fse_pkg::SEG_BITS-1:0]       out_segment
);

  // A stalled result word holds its contents
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_level)
      && $stable(out_running) && $stable(out_segment))
    else $error("result word changed while stalled");

  // Sequencer is busy right after taking a word
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted on back-to-back cycles");

  // Idle words carry segment zero and a rest level
  a_idle_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_running |-> out_segment == fse_pkg::SEG_IDLE
      && (out_level == '0 || out_level == fse_pkg::LEVEL_MAX))
    else $error("idle word with segment or level set");

  // Running words carry a real segment code
  a_run_segment: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_running |-> out_segment == fse_pkg::SEG_ATTACK
      || out_segment == fse_pkg::SEG_DECAY || out_segment == fse_pkg::SEG_SUSTAIN
      || out_segment == fse_pkg::SEG_RELEASE)
    else $error("running word without a segment");

endmodule

bind four_segment_linear_envelope fse_port_checker u_fse_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_level   (out_level),
  .out_running (out_running),
  .out_segment (out_segment)
);

`default_nettype wire
